// File: rtl/core/rcbpq_pkg.sv
// ----------------------------------------------------------------------------
// rcbpq_pkg
// Shared types and constants for the reference-counted buffer pool queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rcbpq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam bit PREFILL_DEF = 1'b1;

  localparam int HANDLE_W    = 4;
  localparam int NUM_HANDLES = 16;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int CAP_W       = 5;
  localparam int USE_W       = 8;
  localparam int CAP_RESET   = 16;

  localparam logic [USE_W-1:0] USE_MAX = 8'd255;

  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_GET   = 3'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd2;
  localparam logic [OP_W-1:0] OP_INC   = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEC   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [CAP_W-1:0]    queued;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/rcbpq_ram.sv
// ----------------------------------------------------------------------------
// rcbpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcbpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/refcounted_buffer_pool_queue.sv
// ----------------------------------------------------------------------------
// refcounted_buffer_pool_queue
// Circular queue of frame handles with a per-handle use count. Each request
// is done in order: a synchronous read of the slot and use-count memories as
// it is accepted, then a modify and write back in the EXEC state. The result
// is registered at the write-back edge and strobed in the cycle after that
// edge; no new request is accepted while busy. Reset and each capacity write
// empty or prefill the queue at once.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_buffer_pool_queue #(
  parameter int DEPTH   = rcbpq_pkg::DEPTH_DEF,
  parameter bit PREFILL = rcbpq_pkg::PREFILL_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire rcbpq_pkg::req_t            request,
  output logic                            result_valid,
  output rcbpq_pkg::rsp_t                 result,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [rcbpq_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW = ((IW > rcbpq_pkg::CAP_W) ? IW : rcbpq_pkg::CAP_W) + 1;
  localparam int HW = rcbpq_pkg::HANDLE_W;
  localparam int CW = rcbpq_pkg::CAP_W;
  localparam int UW = rcbpq_pkg::USE_W;
  localparam int CAP_RST =
    (DEPTH < rcbpq_pkg::CAP_RESET) ? DEPTH : rcbpq_pkg::CAP_RESET;

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_EXEC = 1'b1;

  logic                                state;
  logic [rcbpq_pkg::OP_W-1:0]          op_q;
  logic [HW-1:0]                       handle_q;
  logic [CW-1:0]                       capacity;
  logic [IW-1:0]                       head_index;
  logic [IW-1:0]                       tail_index;
  logic [CW-1:0]                       fill_count;
  logic [DEPTH-1:0]                    slot_valid;
  logic [rcbpq_pkg::NUM_HANDLES-1:0]   use_valid;

  logic [IW-1:0]                       head_next;
  logic [IW-1:0]                       tail_next;
  logic [CW-1:0]                       fill_next;
  logic [CW-1:0]                       cap_clamped;
  rcbpq_pkg::rsp_t                     result_next;

  logic [HW-1:0]                       slot_q;
  logic [HW-1:0]                       slot_rd;
  logic [UW-1:0]                       use_q;
  logic [UW-1:0]                       use_rd;
  logic                                slot_we;
  logic                                use_we;
  logic [UW-1:0]                       use_wdata;
  logic                                do_put;
  logic                                is_full;
  logic [AW-1:0]                       head_inc;
  logic [AW-1:0]                       tail_inc;

  assign busy      = (state == STATE_EXEC);
  assign cfg_ready = ~busy;

  rcbpq_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (tail_index),
    .wdata (handle_q),
    .raddr (head_index),
    .rdata (slot_q)
  );

  rcbpq_ram #(
    .WIDTH (UW),
    .DEPTH (rcbpq_pkg::NUM_HANDLES)
  ) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (handle_q),
    .wdata (use_wdata),
    .raddr (request.handle),
    .rdata (use_q)
  );

  // Entries not written since reset or the last capacity write read as their
  // initial contents.
  always_comb begin
    if (slot_valid[head_index]) begin
      slot_rd = slot_q;
    end else if (PREFILL) begin
      slot_rd = HW'(head_index);
    end else begin
      slot_rd = '0;
    end
    use_rd = use_valid[handle_q] ? use_q : '0;
  end

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CW'(1);
    end else if (AW'(cfg_data) > AW'(DEPTH)) begin
      cap_clamped = CW'(DEPTH);
    end else begin
      cap_clamped = cfg_data;
    end
  end

  always_comb begin
    head_inc   = AW'(head_index) + AW'(1);
    tail_inc   = AW'(tail_index) + AW'(1);
    is_full    = (fill_count >= capacity);
    head_next  = head_index;
    tail_next  = tail_index;
    fill_next  = fill_count;
    slot_we    = 1'b0;
    use_we     = 1'b0;
    use_wdata  = use_rd;
    do_put     = 1'b0;
    result_next.status     = rcbpq_pkg::ST_OK;
    result_next.handle_out = '0;
    case (op_q)
      rcbpq_pkg::OP_PUT: begin
        do_put = 1'b1;
      end
      rcbpq_pkg::OP_GET: begin
        if (fill_count == '0) begin
          result_next.status = rcbpq_pkg::ST_EMPTY;
        end else begin
          result_next.handle_out = slot_rd;
          head_next = (head_inc >= AW'(capacity)) ? '0 : IW'(head_inc);
          fill_next = fill_count - CW'(1);
        end
      end
      rcbpq_pkg::OP_INC: begin
        use_we = busy;
        if (use_rd != rcbpq_pkg::USE_MAX) begin
          use_wdata = use_rd + UW'(1);
        end
      end
      rcbpq_pkg::OP_FREE: begin
        if (use_rd != '0) begin
          use_we    = busy;
          use_wdata = use_rd - UW'(1);
          result_next.status = rcbpq_pkg::ST_DEC;
        end else begin
          do_put = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (do_put) begin
      if (is_full) begin
        result_next.status = rcbpq_pkg::ST_FULL;
      end else begin
        slot_we   = busy;
        tail_next = (tail_inc >= AW'(capacity)) ? '0 : IW'(tail_inc);
        fill_next = fill_count + CW'(1);
      end
    end
    result_next.queued = fill_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= STATE_IDLE;
      result_valid <= 1'b0;
      capacity     <= CW'(CAP_RST);
      head_index   <= '0;
      tail_index   <= '0;
      fill_count   <= PREFILL ? CW'(CAP_RST) : '0;
      slot_valid   <= '0;
      use_valid    <= '0;
    end else begin
      result_valid <= (state == STATE_EXEC);
      case (state)
        STATE_IDLE: begin
          if (start) begin
            state    <= STATE_EXEC;
            op_q     <= request.op;
            handle_q <= request.handle;
          end
          if (cfg_valid && cfg_ready) begin
            capacity   <= cap_clamped;
            head_index <= '0;
            tail_index <= '0;
            fill_count <= PREFILL ? cap_clamped : '0;
            slot_valid <= '0;
            use_valid  <= '0;
          end
        end
        STATE_EXEC: begin
          state        <= STATE_IDLE;
          result       <= result_next;
          head_index   <= head_next;
          tail_index   <= tail_next;
          fill_count   <= fill_next;
          if (slot_we) begin
            slot_valid[tail_index] <= 1'b1;
          end
          if (use_we) begin
            use_valid[handle_q] <= 1'b1;
          end
        end
        default: begin
          state <= STATE_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
